### rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
`timescale 1ns / 1ps
package adsr_pkg;

  typedef enum logic [2:0] {
    PH_NOTE_ON = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4,
    PH_OFF     = 3'd5
  } phase_t;

  localparam int unsigned LEN_W   = 20;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned VOL_W   = 16;
  localparam int unsigned VEL_W   = 15;
  localparam int unsigned NOTE_W  = 32;
  localparam int unsigned EL_W    = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 20;

  localparam logic [CIDX_W-1:0] REG_ATTACK_LEN   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DECAY_LEN    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ATTACK_GAIN  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DECAY_GAIN   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SUSTAIN_GAIN = 3'd4;
  localparam logic [CIDX_W-1:0] REG_RELEASE_GAIN = 3'd5;

  localparam logic [LEN_W-1:0]  RST_ATTACK_LEN   = 20'd20000;
  localparam logic [LEN_W-1:0]  RST_DECAY_LEN    = 20'd20000;
  localparam logic [GAIN_W-1:0] RST_ATTACK_GAIN  = 16'd17203;
  localparam logic [GAIN_W-1:0] RST_DECAY_GAIN   = 16'd15237;
  localparam logic [GAIN_W-1:0] RST_SUSTAIN_GAIN = 16'd16384;
  localparam logic [GAIN_W-1:0] RST_RELEASE_GAIN = 16'd16220;

  // Rounding half up before dropping the 14 fraction bits of a Q2.14 gain
  localparam logic [31:0] ROUND_HALF = 32'd8192;

  typedef struct packed {
    logic [LEN_W-1:0]  attack_length_us;
    logic [LEN_W-1:0]  decay_length_us;
    logic [GAIN_W-1:0] attack_gain;
    logic [GAIN_W-1:0] decay_gain;
    logic [GAIN_W-1:0] sustain_gain;
    logic [GAIN_W-1:0] release_gain;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [NOTE_W-1:0] note_length_us;
    logic [VEL_W-1:0]  note_velocity;
    logic [EL_W-1:0]   elapsed_us;
  } item_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic [2:0]       phase;
  } result_t;

endpackage

### rtl/adsr_cfg.sv
// Configuration register file for the envelope generator.
`timescale 1ns / 1ps
module adsr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [adsr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [adsr_pkg::CDATA_W-1:0]  cfg_data,
  output adsr_pkg::cfg_t                cfg
);
  import adsr_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_length_us <= RST_ATTACK_LEN;
      cfg_r.decay_length_us  <= RST_DECAY_LEN;
      cfg_r.attack_gain      <= RST_ATTACK_GAIN;
      cfg_r.decay_gain       <= RST_DECAY_GAIN;
      cfg_r.sustain_gain     <= RST_SUSTAIN_GAIN;
      cfg_r.release_gain     <= RST_RELEASE_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ATTACK_LEN:   cfg_r.attack_length_us <= cfg_data[LEN_W-1:0];
        REG_DECAY_LEN:    cfg_r.decay_length_us  <= cfg_data[LEN_W-1:0];
        REG_ATTACK_GAIN:  cfg_r.attack_gain      <= cfg_data[GAIN_W-1:0];
        REG_DECAY_GAIN:   cfg_r.decay_gain       <= cfg_data[GAIN_W-1:0];
        REG_SUSTAIN_GAIN: cfg_r.sustain_gain     <= cfg_data[GAIN_W-1:0];
        REG_RELEASE_GAIN: cfg_r.release_gain     <= cfg_data[GAIN_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

### rtl/adsr_core.sv
// Envelope state and its combinational update for one item.
`timescale 1ns / 1ps
module adsr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  adsr_pkg::item_t     item,
  input  adsr_pkg::cfg_t      cfg,
  output adsr_pkg::result_t   res
);
  import adsr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [VOL_W-1:0]  level_r, level_nxt;
  logic [VEL_W-1:0]  held_r, held_nxt;
  logic [31:0]       elapsed_r, elapsed_nxt;
  logic [31:0]       limit_r, limit_nxt;
  logic [31:0]       sustain_len_r, sustain_len_nxt;
  logic [31:0]       release_len_r, release_len_nxt;

  // working values for a tick
  phase_t            cur_phase;
  logic [VOL_W-1:0]  cur_level;
  logic [31:0]       cur_elapsed;
  logic [31:0]       cur_limit;
  logic [32:0]       sum_wide;
  logic [31:0]       sum_sat;
  logic              running;
  logic [GAIN_W-1:0] gain;
  logic [31:0]       product;
  logic [31:0]       rounded;
  logic [17:0]       scaled;
  logic [VOL_W-1:0]  scaled_sat;
  logic [VOL_W-1:0]  cap;
  logic [VOL_W-1:0]  floor_v;

  // start split of the note length
  logic [31:0]       atk_len32, dec_len32;
  logic [31:0]       rem1, rem2, rel_half;

  always_comb begin
    atk_len32 = {12'd0, cfg.attack_length_us};
    dec_len32 = {12'd0, cfg.decay_length_us};
    rem1      = (item.note_length_us > atk_len32) ? item.note_length_us - atk_len32 : 32'd0;
    rem2      = (rem1 > dec_len32) ? rem1 - dec_len32 : 32'd0;
    rel_half  = {1'b0, rem2[31:1]};
  end

  always_comb begin
    // a tick in note_on first enters attack with a fresh timer
    if (phase_r == PH_NOTE_ON) begin
      cur_phase   = PH_ATTACK;
      cur_level   = {1'b0, held_r};
      cur_elapsed = 32'd0;
      cur_limit   = atk_len32;
    end else begin
      cur_phase   = phase_r;
      cur_level   = level_r;
      cur_elapsed = elapsed_r;
      cur_limit   = limit_r;
    end
    sum_wide = {1'b0, cur_elapsed} + {17'd0, item.elapsed_us};
    sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    running  = sum_sat < cur_limit;

    unique case (cur_phase)
      PH_ATTACK:  gain = cfg.attack_gain;
      PH_DECAY:   gain = cfg.decay_gain;
      PH_SUSTAIN: gain = cfg.sustain_gain;
      default:    gain = cfg.release_gain;
    endcase
    product    = {16'd0, cur_level} * {16'd0, gain};
    rounded    = product + ROUND_HALF;  // cannot wrap: 16x16 max plus half stays in 32 bits
    scaled     = rounded[31:14];
    scaled_sat = (|scaled[17:16]) ? {VOL_W{1'b1}} : scaled[VOL_W-1:0];
    cap        = {held_r, 1'b0};
    floor_v    = {2'd0, held_r[VEL_W-1:1]};
  end

  always_comb begin
    phase_nxt       = phase_r;
    level_nxt       = level_r;
    held_nxt        = held_r;
    elapsed_nxt     = elapsed_r;
    limit_nxt       = limit_r;
    sustain_len_nxt = sustain_len_r;
    release_len_nxt = release_len_r;
    if (item.op) begin
      release_len_nxt = rel_half;
      sustain_len_nxt = rem2 - rel_half;
      held_nxt        = item.note_velocity;
      level_nxt       = {1'b0, item.note_velocity};
      phase_nxt       = PH_NOTE_ON;
    end else if (phase_r == PH_OFF) begin
      level_nxt = '0;
    end else begin
      level_nxt   = cur_level;
      phase_nxt   = cur_phase;
      elapsed_nxt = cur_elapsed;
      limit_nxt   = cur_limit;
      if (running) begin
        elapsed_nxt = sum_sat;
        unique case (cur_phase)
          PH_ATTACK: level_nxt = (scaled_sat > cap) ? cap : scaled_sat;
          PH_DECAY:  level_nxt = (scaled_sat < floor_v) ? floor_v : scaled_sat;
          default:   level_nxt = scaled_sat;
        endcase
      end else begin
        elapsed_nxt = 32'd0;
        unique case (cur_phase)
          PH_ATTACK: begin
            phase_nxt = PH_DECAY;
            limit_nxt = dec_len32;
          end
          PH_DECAY: begin
            phase_nxt = PH_SUSTAIN;
            limit_nxt = sustain_len_r;
          end
          PH_SUSTAIN: begin
            phase_nxt = PH_RELEASE;
            limit_nxt = release_len_r;
          end
          default: begin
            // release done; timer keeps the summed value
            phase_nxt   = PH_OFF;
            level_nxt   = '0;
            elapsed_nxt = sum_sat;
          end
        endcase
      end
    end
  end

  assign res.volume = level_nxt;
  assign res.phase  = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OFF;
      level_r       <= '0;
      held_r        <= '0;
      elapsed_r     <= '0;
      limit_r       <= '0;
      sustain_len_r <= '0;
      release_len_r <= '0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      level_r       <= level_nxt;
      held_r        <= held_nxt;
      elapsed_r     <= elapsed_nxt;
      limit_r       <= limit_nxt;
      sustain_len_r <= sustain_len_nxt;
      release_len_r <= release_len_nxt;
    end
  end

endmodule

### rtl/adsr_envelope_generator_top.sv
// Top level of the ADSR envelope generator: input and result registers around the core.
//
// Input channel (in_*): op = 1 starts a note with in_note_length_us and
// in_note_velocity; op = 0 is a tick that advances the envelope by in_elapsed_us.
// Every item yields exactly one result item on out_volume / out_phase.
// An item is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// Configuration (cfg_*): six registers, written with cfg_valid and cfg_ready
// (always ready); write only while no item is in flight.
// Path: an accepted item goes through the input register, then the result
// register, before its result shows on out_*.
// Throughput: one item per cycle while out_stall is low; the envelope state
// updates in the same cycle the item leaves the input register.
// Stall: with out_stall high the result register holds, one more item can
// wait in the input register, then in_stall rises.
// Reset (rst_n low, synchronous): both registers empty, envelope off at
// volume 0, configuration back to defaults.
`timescale 1ns / 1ps
module adsr_envelope_generator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [adsr_pkg::NOTE_W-1:0]   in_note_length_us,
  input  logic [adsr_pkg::VEL_W-1:0]    in_note_velocity,
  input  logic [adsr_pkg::EL_W-1:0]     in_elapsed_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [adsr_pkg::VOL_W-1:0]    out_volume,
  output logic [2:0]                    out_phase,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [adsr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [adsr_pkg::CDATA_W-1:0]  cfg_data
);
  import adsr_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    out_free;
  logic    advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;

  adsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adsr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.op             <= in_op;
      item_r.note_length_us <= in_note_length_us;
      item_r.note_velocity  <= in_note_velocity;
      item_r.elapsed_us     <= in_elapsed_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_volume = out_r.volume;
  assign out_phase  = out_r.phase;

endmodule

### rtl/adsr_checker.sv
// Port-level checks for the envelope generator, bound to the top level.
`timescale 1ns / 1ps
module adsr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [adsr_pkg::VOL_W-1:0]  out_volume,
  input logic [2:0]                  out_phase
);
  import adsr_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_volume) && $stable(out_phase))
    else $error("stalled result changed");

  // off always reads silent
  a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_OFF |-> out_volume == '0)
    else $error("nonzero volume while off");

  // a start result carries the 15-bit velocity
  a_note_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_NOTE_ON |-> !out_volume[VOL_W-1])
    else $error("note_on volume above velocity range");

endmodule

bind adsr_envelope_generator_top adsr_checker u_adsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_volume (out_volume),
  .out_phase  (out_phase)
);

### sim/tb_adsr_envelope_generator_top.sv
// Self-checking testbench for the ADSR envelope generator: random notes and ticks vs a predictor.
`timescale 1ns / 1ps
module tb_adsr_envelope_generator_top;
  import adsr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned REG_COUNT   = 6;
  localparam int unsigned MAX_PRINTS  = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = 1'b0;
  logic [NOTE_W-1:0]  in_note_length_us = '0;
  logic [VEL_W-1:0]   in_note_velocity = '0;
  logic [EL_W-1:0]    in_elapsed_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VOL_W-1:0]   out_volume;
  logic [2:0]         out_phase;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;

  adsr_envelope_generator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_note_length_us (in_note_length_us),
    .in_note_velocity  (in_note_velocity),
    .in_elapsed_us     (in_elapsed_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_volume        (out_volume),
    .out_phase         (out_phase),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Envelope predictor state and its copy of the registers
  cfg_t shadow_cfg = '{RST_ATTACK_LEN, RST_DECAY_LEN, RST_ATTACK_GAIN, RST_DECAY_GAIN,
                       RST_SUSTAIN_GAIN, RST_RELEASE_GAIN};
  phase_t           env_phase = PH_OFF;
  logic [VOL_W-1:0] env_level = '0;
  logic [VEL_W-1:0] env_vel = '0;
  logic [31:0]      timer_us = '0;
  logic [31:0]      timer_limit = '0;
  logic [31:0]      hold_len = '0;
  logic [31:0]      fade_len = '0;

  item_t       note_q[$];
  result_t     predicted_q[$];
  item_t       tx_item;
  item_t       rx_item;
  result_t     want;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 50;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        in_took = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (errors < MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic logic [VOL_W-1:0] apply_gain(input logic [VOL_W-1:0] lv,
                                                  input logic [GAIN_W-1:0] g);
    logic [32:0] prod;
    prod = {17'd0, lv} * {17'd0, g} + {1'b0, ROUND_HALF};
    prod = prod >> 14;
    return (prod > 33'd65535) ? '1 : prod[VOL_W-1:0];
  endfunction

  function automatic result_t advance_envelope(input item_t it);
    logic [31:0] rem;
    logic [31:0] sum;
    logic [31:0] att_len;
    logic [31:0] dec_len;
    logic        running;
    result_t     r;
    att_len = {12'd0, shadow_cfg.attack_length_us};
    dec_len = {12'd0, shadow_cfg.decay_length_us};
    if (it.op) begin
      rem = (it.note_length_us > att_len) ? it.note_length_us - att_len : '0;
      rem = (rem > dec_len) ? rem - dec_len : '0;
      fade_len  = rem >> 1;
      hold_len  = rem - fade_len;
      env_vel   = it.note_velocity;
      env_level = {1'b0, it.note_velocity};
      env_phase = PH_NOTE_ON;
    end else begin
      // first tick after a start reloads the level and opens the attack
      if (env_phase == PH_NOTE_ON) begin
        env_level   = {1'b0, env_vel};
        env_phase   = PH_ATTACK;
        timer_us    = '0;
        timer_limit = att_len;
      end
      if (env_phase >= PH_ATTACK && env_phase <= PH_RELEASE) begin
        sum = timer_us + {16'd0, it.elapsed_us};
        if (sum < timer_us) sum = '1;
        timer_us = sum;
        running  = timer_us < timer_limit;
        case (env_phase)
          PH_ATTACK: begin
            if (running) begin
              env_level = apply_gain(env_level, shadow_cfg.attack_gain);
              if (env_level > {env_vel, 1'b0}) env_level = {env_vel, 1'b0};
            end else begin
              env_phase   = PH_DECAY;
              timer_us    = '0;
              timer_limit = dec_len;
            end
          end
          PH_DECAY: begin
            if (running) begin
              env_level = apply_gain(env_level, shadow_cfg.decay_gain);
              if (env_level < {2'b0, env_vel[VEL_W-1:1]}) env_level = {2'b0, env_vel[VEL_W-1:1]};
            end else begin
              env_phase   = PH_SUSTAIN;
              timer_us    = '0;
              timer_limit = hold_len;
            end
          end
          PH_SUSTAIN: begin
            if (running) begin
              env_level = apply_gain(env_level, shadow_cfg.sustain_gain);
            end else begin
              env_phase   = PH_RELEASE;
              timer_us    = '0;
              timer_limit = fade_len;
            end
          end
          PH_RELEASE: begin
            if (running) begin
              env_level = apply_gain(env_level, shadow_cfg.release_gain);
            end else begin
              env_phase = PH_OFF;
              env_level = '0;
            end
          end
          default: ;
        endcase
      end else begin
        env_phase = PH_OFF;
        env_level = '0;
      end
    end
    r.volume = env_level;
    r.phase  = env_phase;
    return r;
  endfunction

  // Driver: one item at a time from note_q, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (note_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tx_item = note_q.pop_front();
        in_valid          <= 1'b1;
        in_op             <= tx_item.op;
        in_note_length_us <= tx_item.note_length_us;
        in_note_velocity  <= tx_item.note_velocity;
        in_elapsed_us     <= tx_item.elapsed_us;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: register writes, accepted items, result checks, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK_LEN:   shadow_cfg.attack_length_us = cfg_data[LEN_W-1:0];
          REG_DECAY_LEN:    shadow_cfg.decay_length_us  = cfg_data[LEN_W-1:0];
          REG_ATTACK_GAIN:  shadow_cfg.attack_gain      = cfg_data[GAIN_W-1:0];
          REG_DECAY_GAIN:   shadow_cfg.decay_gain       = cfg_data[GAIN_W-1:0];
          REG_SUSTAIN_GAIN: shadow_cfg.sustain_gain     = cfg_data[GAIN_W-1:0];
          REG_RELEASE_GAIN: shadow_cfg.release_gain     = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        rx_item.op             = in_op;
        rx_item.note_length_us = in_note_length_us;
        rx_item.note_velocity  = in_note_velocity;
        rx_item.elapsed_us     = in_elapsed_us;
        predicted_q.push_back(advance_envelope(rx_item));
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          flag_error($sformatf("unexpected result: volume %0d phase %0d",
                               out_volume, out_phase));
        end else begin
          want = predicted_q.pop_front();
          if (out_volume !== want.volume)
            flag_error($sformatf("volume %0d, expected %0d", out_volume, want.volume));
          if (out_phase !== want.phase)
            flag_error($sformatf("phase %0d, expected %0d", out_phase, want.phase));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("adsr_envelope_generator_top test failed");
        $finish;
      end
    end
  end

  task automatic push_item(input item_t it);
    note_q.push_back(it);
    items_queued++;
  endtask

  // Unused fields carry random bits so every input bit toggles
  task automatic push_start(input logic [NOTE_W-1:0] len, input logic [VEL_W-1:0] vel);
    item_t it;
    it.op             = 1'b1;
    it.note_length_us = len;
    it.note_velocity  = vel;
    it.elapsed_us     = EL_W'($urandom());
    push_item(it);
  endtask

  task automatic push_tick(input logic [EL_W-1:0] el);
    item_t it;
    it.op             = 1'b0;
    it.note_length_us = $urandom();
    it.note_velocity  = VEL_W'($urandom());
    it.elapsed_us     = el;
    push_item(it);
  endtask

  task automatic queue_noise();
    item_t it;
    it.op             = 1'($urandom_range(1));
    it.note_length_us = $urandom();
    it.note_velocity  = VEL_W'($urandom());
    it.elapsed_us     = EL_W'($urandom());
    push_item(it);
  endtask

  // A start followed by ticks sized to walk the note through its phases
  task automatic queue_note();
    logic [NOTE_W-1:0] len;
    logic [VEL_W-1:0]  vel;
    int unsigned       att_dec;
    int unsigned       span;
    int unsigned       ticks;
    int unsigned       step;
    int unsigned       el;
    int unsigned       i;
    att_dec = 32'(shadow_cfg.attack_length_us) + 32'(shadow_cfg.decay_length_us);
    case ($urandom_range(9))
      0:       len = $urandom();
      1:       len = $urandom_range(att_dec);
      default: len = att_dec + $urandom_range(150000);
    endcase
    case ($urandom_range(7))
      0:       vel = '0;
      1:       vel = '1;
      default: vel = VEL_W'($urandom_range(32767));
    endcase
    push_start(len, vel);
    span = (len > att_dec) ? len : att_dec;
    if (span > 4000000) span = 4000000;
    span  = span + 2000;
    ticks = $urandom_range(4, 40);
    step  = span / ticks;
    for (i = 0; i < ticks; i++) begin
      case ($urandom_range(19))
        0:       el = 0;
        1:       el = 65535;
        default: el = step * $urandom_range(50, 150) / 100;
      endcase
      if (el > 65535) el = 65535;
      push_tick(EL_W'(el));
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [CDATA_W-1:0] att, dec, ag, dg, sg, rg);
    logic [CIDX_W-1:0] junk_idx;
    junk_idx = CIDX_W'($urandom_range(REG_COUNT, (1 << CIDX_W) - 1));
    write_reg(REG_ATTACK_LEN, att);
    write_reg(REG_DECAY_LEN, dec);
    write_reg(REG_ATTACK_GAIN, ag);
    // index past the register list: must be ignored
    write_reg(junk_idx, CDATA_W'($urandom()));
    write_reg(REG_DECAY_GAIN, dg);
    write_reg(REG_SUSTAIN_GAIN, sg);
    write_reg(REG_RELEASE_GAIN, rg);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CDATA_W-1:0] pick_length();
    return ($urandom_range(3) == 0) ? CDATA_W'($urandom_range(20'hFFFFF)) :
                                      CDATA_W'($urandom_range(60000));
  endfunction

  // Upper data bits are don't-care for gains, so fill them randomly
  function automatic logic [CDATA_W-1:0] pick_gain();
    logic [CDATA_W-1:0] w;
    w = CDATA_W'($urandom());
    w[GAIN_W-1:0] = $urandom_range(1) ? GAIN_W'($urandom_range(12384, 20384)) :
                                        GAIN_W'($urandom_range(65535));
    return w;
  endfunction

  task automatic drain_all();
    while (items_taken != items_queued || predicted_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int unsigned ph;
    int unsigned mark;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: ticks while off, a maximal note, a note hitting every boundary, then a zero-velocity note
    push_tick(0);
    push_tick('1);
    push_start('1, '1);
    push_tick(0);
    push_tick(100);
    push_tick('1);
    push_tick(1000);
    push_tick('1);
    push_tick('1);
    push_start(32'd40010, 15'h4000);
    push_tick(19999);
    push_tick(1);
    push_tick(20000);
    push_tick(4);
    push_tick(1);
    push_tick(5);
    push_tick(7);
    push_start(32'd30000, '0);
    push_tick(10);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_all();
      case (ph)
        0: load_settings('0, '0, '0, '0, '0, '0);
        1: load_settings('1, '1, '1, '1, '1, '1);
        2: load_settings(RST_ATTACK_LEN, RST_DECAY_LEN, CDATA_W'(RST_ATTACK_GAIN),
                         CDATA_W'(RST_DECAY_GAIN), CDATA_W'(RST_SUSTAIN_GAIN),
                         CDATA_W'(RST_RELEASE_GAIN));
        default: load_settings(pick_length(), pick_length(), pick_gain(), pick_gain(),
                               pick_gain(), pick_gain());
      endcase
      if (ph == 0) begin
        // zero-length attack and decay, short sustain and release, zero gains
        push_start(32'd5, '1);
        push_tick(0);
        push_tick(0);
        push_tick(2);
        push_tick(1);
        push_tick(1);
        push_tick(1);
      end
      send_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 50 : 0;
      recv_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 21 : 0;
      mark = items_queued;
      while (items_queued - mark < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) queue_noise();
        else queue_note();
      end
      if (ph == 6) begin
        // long receiver hold-off while the driver keeps offering items
        @(posedge clk);
        hold_req = 1'b1;
      end
    end

    drain_all();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("adsr_envelope_generator_top test passed");
    end else begin
      $display("adsr_envelope_generator_top test failed");
    end
    $finish;
  end

endmodule
